// ===== src/integer_set_store_unit_macros.svh =====
// Assertion macros for the integer set store unit.
`ifndef INTEGER_SET_STORE_UNIT_MACROS_SVH
`define INTEGER_SET_STORE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define ISS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ISS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ISS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ISS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/iss_pkg.sv =====
// Shared constants, codes and structs of the integer set store unit.
package iss_pkg;

  localparam int DEPTH = 16;
  localparam int VW    = 32;
  localparam int IW    = 4;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int XW    = (CW > IW) ? CW : IW;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_SAME    = 2'd1,
    ST_REFUSED = 2'd2
  } status_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [VW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    status_t       status;
    logic [VW-1:0] read_data;
    logic [CW-1:0] member_count;
  } res_t;

endpackage

// ===== src/iss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module iss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/iss_ctrl.sv =====
// Sequencer of the set store: membership scan, compaction shift and indexed read.
module iss_ctrl
  import iss_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_opcode,
  input  logic [VW-1:0] in_value,
  input  logic [IW-1:0] in_index,
  output logic          idle,
  input  logic [VW-1:0] rd_data,
  output ram_req_t      ram_req,
  output logic          res_valid,
  output res_t          res,
  input  logic          res_take
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_READ  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  op_t           op_r, op_nxt;
  logic [VW-1:0] value_r, value_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          cmp_valid_r, cmp_valid_nxt;
  logic [AW-1:0] cmp_pos_r, cmp_pos_nxt;
  logic [CW-1:0] count_r, count_nxt;
  status_t       status_r, status_nxt;
  logic          issue;
  logic          match;

  assign issue = (ptr_r < count_r);
  assign match = cmp_valid_r && (rd_data == value_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    value_nxt     = value_r;
    ptr_nxt       = ptr_r;
    cmp_valid_nxt = cmp_valid_r;
    cmp_pos_nxt   = cmp_pos_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    ram_req       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt        = op_t'(in_opcode);
          value_nxt     = in_value;
          ptr_nxt       = '0;
          cmp_valid_nxt = 1'b0;
          unique case (op_t'(in_opcode))
            OP_INSERT, OP_REMOVE: begin
              state_nxt = S_SCAN;
            end
            OP_READ: begin
              if (XW'(in_index) < XW'(count_r)) begin
                ptr_nxt   = CW'(in_index);
                state_nxt = S_READ;
              end else begin
                status_nxt = ST_REFUSED;
                state_nxt  = S_RESP;
              end
            end
            default: begin
              status_nxt = ST_REFUSED;
              state_nxt  = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (match) begin
          if (op_r == OP_INSERT) begin
            status_nxt = ST_SAME;
            state_nxt  = S_RESP;
          end else begin
            // drop the read in flight, restart reading just above the hit
            ptr_nxt       = CW'(cmp_pos_r) + CW'(1);
            cmp_valid_nxt = 1'b0;
            state_nxt     = S_SHIFT;
          end
        end else if (!issue && !cmp_valid_r) begin
          if (op_r == OP_INSERT) begin
            if (count_r == CW'(DEPTH)) begin
              status_nxt = ST_REFUSED;
            end else begin
              ram_req.we    = 1'b1;
              ram_req.waddr = count_r[AW-1:0];
              ram_req.wdata = value_r;
              count_nxt     = count_r + CW'(1);
              status_nxt    = ST_DONE;
            end
          end else begin
            status_nxt = ST_SAME;
          end
          state_nxt = S_RESP;
        end else begin
          ram_req.re    = issue;
          ram_req.raddr = ptr_r[AW-1:0];
          cmp_valid_nxt = issue;
          cmp_pos_nxt   = ptr_r[AW-1:0];
          if (issue) begin
            ptr_nxt = ptr_r + CW'(1);
          end
        end
      end
      S_SHIFT: begin
        if (cmp_valid_r) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = cmp_pos_r - AW'(1);
          ram_req.wdata = rd_data;
        end
        if (!issue && !cmp_valid_r) begin
          count_nxt  = count_r - CW'(1);
          status_nxt = ST_DONE;
          state_nxt  = S_RESP;
        end else begin
          ram_req.re    = issue;
          ram_req.raddr = ptr_r[AW-1:0];
          cmp_valid_nxt = issue;
          cmp_pos_nxt   = ptr_r[AW-1:0];
          if (issue) begin
            ptr_nxt = ptr_r + CW'(1);
          end
        end
      end
      S_READ: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = ptr_r[AW-1:0];
        status_nxt    = ST_DONE;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_valid_r <= cmp_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    value_r   <= value_nxt;
    ptr_r     <= ptr_nxt;
    cmp_pos_r <= cmp_pos_nxt;
    status_r  <= status_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);

  always_comb begin
    res.status       = status_r;
    res.member_count = count_r;
    res.read_data    = ((op_r == OP_READ) && (status_r == ST_DONE)) ? rd_data : '0;
  end

endmodule

// ===== src/integer_set_store_unit.sv =====
// Top level of the integer set store unit: sequencer, entry RAM and result register.
//
// Keeps a set of up to DEPTH distinct signed 32-bit values in insertion order.
// Input channel (in_valid/in_stall): one beat carries opcode, value and index;
//   insert appends a value not yet present, remove deletes a value and closes
//   the gap, read returns the entry at index. Every beat gives one result.
// Result channel (out_valid/out_stall): status, read data and member count.
// Path from accept to out_valid:
//   read: one RAM read; refused opcode or out-of-range index: straight to the result;
//   insert or remove that misses: a scan over all entries,
//   one RAM read and one compare per entry;
//   insert or remove that hits: the scan up to the hit; a remove then runs the
//   compaction, which moves one entry per cycle through the same RAM ports.
// The single read port of the entry RAM and the one comparator set the rate.
// One item is in work at a time: in_stall stays high from accept until the
// result is loaded into the output register, so the next beat can be taken
// once that load is done, even while the receiver stalls; a second result
// then waits in the sequencer.
// Reset empties the set (count zero); entry contents are not cleared.
module integer_set_store_unit
  import iss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_opcode,
  input  logic signed [VW-1:0] in_value,
  input  logic [IW-1:0]        in_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic signed [VW-1:0] out_read_data,
  output logic [CW-1:0]        out_member_count
);

`include "integer_set_store_unit_macros.svh"

  logic          idle;
  ram_req_t      ram_req;
  logic [VW-1:0] rd_data;
  logic          res_valid;
  res_t          res;
  logic          res_take;
  logic          out_valid_r, out_valid_nxt;
  res_t          out_res_r;

  // Take a new beat only when the sequencer sits idle.
  assign in_stall = !idle;

  iss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_value  (in_value),
    .in_index  (in_index),
    .idle      (idle),
    .rd_data   (rd_data),
    .ram_req   (ram_req),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  iss_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_req.we),
    .wr_addr (ram_req.waddr),
    .wr_data (ram_req.wdata),
    .rd_en   (ram_req.re),
    .rd_addr (ram_req.raddr),
    .rd_data (rd_data)
  );

  // Load the result register when it is empty or draining this cycle.
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload while stalled; advance only on a load.
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_read_data    = out_res_r.read_data;
  assign out_member_count = out_res_r.member_count;

  // An accepted beat always leaves the sequencer busy on the next cycle.
  `ISS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // The member count never passes the capacity.
  `ISS_ASSERT_NOW(a_count_bound, clk, rst_n, out_valid, out_member_count <= CW'(DEPTH))
  // Only a successful read carries data.
  `ISS_ASSERT_NOW(a_data_zero, clk, rst_n, out_valid && (out_status != ST_DONE), out_read_data == '0)
  // A result is offered only while the sequencer is busy with its item.
  `ISS_ASSERT_NOW(a_res_busy, clk, rst_n, res_valid, !idle)

endmodule

// ===== tb/set_outcome_checker.sv =====
// Predicts every set operation of the integer set store unit and checks each result beat.
module set_outcome_checker
  import iss_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  logic [1:0]    in_opcode,
  input  logic [VW-1:0] in_value,
  input  logic [IW-1:0] in_index,
  input  logic          out_valid,
  input  logic          out_stall,
  input  logic [1:0]    out_status,
  input  logic [VW-1:0] out_read_data,
  input  logic [CW-1:0] out_member_count,
  output int            mismatch_count,
  output int            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  logic [VW-1:0] members [DEPTH];
  int            member_total = 0;
  int            fault_total = 0;
  res_t          awaited_q [$];

  // Position of the first live member equal to val, or member_total if absent.
  function automatic int find_member(logic [VW-1:0] val);
    for (int i = 0; i < member_total; i++) begin
      if (members[i] == val) return i;
    end
    return member_total;
  endfunction

  function automatic res_t apply_set_op(logic [1:0] opc, logic [VW-1:0] val,
                                        logic [IW-1:0] idx);
    res_t outcome;
    int   pos;
    outcome.status    = ST_REFUSED;
    outcome.read_data = '0;
    case (opc)
      OP_INSERT: begin
        pos = find_member(val);
        if (pos < member_total) begin
          outcome.status = ST_SAME;
        end else if (member_total < DEPTH) begin
          members[member_total] = val;
          member_total++;
          outcome.status = ST_DONE;
        end
      end
      OP_REMOVE: begin
        pos = find_member(val);
        if (pos >= member_total) begin
          outcome.status = ST_SAME;
        end else begin
          // close the gap: shift later members down one place
          for (int k = pos; k < member_total - 1; k++) members[k] = members[k + 1];
          member_total--;
          outcome.status = ST_DONE;
        end
      end
      OP_READ: begin
        if (int'(idx) < member_total) begin
          outcome.read_data = members[idx];
          outcome.status    = ST_DONE;
        end
      end
      default: ;
    endcase
    outcome.member_count = CW'(member_total);
    return outcome;
  endfunction

  always @(posedge clk) begin
    res_t awaited;
    if (!rst_n) begin
      member_total = 0;
      fault_total  = 0;
      awaited_q.delete();
    end else begin
      // check the result beat before booking the input beat of the same edge
      if (out_valid && !out_stall) begin
        if (awaited_q.size() == 0) begin
          fault_total++;
          if (fault_total <= REPORT_LIMIT)
            $display("%0t: result beat with nothing awaited: status %0d data %h count %0d",
                     $realtime, out_status, out_read_data, out_member_count);
        end else begin
          awaited = awaited_q.pop_front();
          if (out_status != awaited.status || out_read_data != awaited.read_data ||
              out_member_count != awaited.member_count) begin
            fault_total++;
            if (fault_total <= REPORT_LIMIT)
              $display("%0t: mismatch: expected status %0d data %h count %0d, got status %0d data %h count %0d",
                       $realtime, awaited.status, awaited.read_data, awaited.member_count,
                       out_status, out_read_data, out_member_count);
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_q.push_back(apply_set_op(in_opcode, in_value, in_index));
    end
    mismatch_count <= fault_total;
    outstanding    <= awaited_q.size();
  end

endmodule

// ===== tb/tb_integer_set_store_unit.sv =====
// Testbench top: drives directed and random set operations into the store under varied flow control.
module tb_integer_set_store_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import iss_pkg::*;

  // Opcode value the block does not define; it must be refused.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RESET_CYCLES    = 12;
  localparam int ITEMS_PER_PHASE = 350;
  localparam int POOL_SIZE       = 24;  // more than DEPTH, so full-set refusals happen
  localparam int LONG_HOLD       = 120;
  localparam int DRAIN_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT  = 3000;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_opcode = OP_INSERT;
  logic [VW-1:0]        in_value  = '0;
  logic [IW-1:0]        in_index  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_status;
  logic [VW-1:0]        out_read_data;
  logic [CW-1:0]        out_member_count;

  int mismatch_count;
  int outstanding;

  // Flow-control knobs, in percent of cycles spent idle.
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  bit hold_request = 1'b0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  // Values that recur, so inserts hit present members and removes find them.
  logic [VW-1:0] value_pool [POOL_SIZE];

  integer_set_store_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .in_index         (in_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_read_data    (out_read_data),
    .out_member_count (out_member_count)
  );

  set_outcome_checker u_outcome_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .in_index         (in_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_read_data    (out_read_data),
    .out_member_count (out_member_count),
    .mismatch_count   (mismatch_count),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall at random, or hold off for a long stretch on request so the
  // block's output register and sequencer both fill and in_stall rises.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog: count edges where neither channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly pool values, sometimes a fully random word.
  function automatic logic [VW-1:0] pick_value();
    if ($urandom_range(99) < 85) return value_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_opcode(int insert_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < insert_pct) return OP_INSERT;
    if (roll >= 96) return OP_UNUSED;
    return ($urandom_range(1) == 1) ? OP_REMOVE : OP_READ;
  endfunction

  // Offer one beat and hold it until accepted. Drop valid only for an idle
  // gap, so back-to-back beats keep valid high without a lower-and-raise.
  task automatic send_beat(input logic [1:0] opc, input logic [VW-1:0] val,
                           input logic [IW-1:0] idx);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid  <= 1'b1;
    in_opcode <= opc;
    in_value  <= val;
    in_index  <= idx;
    do @(posedge clk); while (in_stall);
  endtask

  // Idle valid and wait until every awaited result has arrived. Wait for a clock
  // edge first so the count includes the beat accepted at the current edge.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Random traffic; the insert share moves every 50 beats so the set swings
  // between nearly empty and full.
  task automatic run_random_phase(input int tx_pct, input int rx_pct, input bit with_hold);
    int insert_pct;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    insert_pct  = 50;
    if (with_hold) hold_request = 1'b1;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      if (n % 50 == 0) insert_pct = 30 + 20 * $urandom_range(2);
      send_beat(pick_opcode(insert_pct), pick_value(), IW'($urandom_range(15)));
    end
    pause_until_drained();
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;

    // Hold reset, then release it on a clock edge.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 9;
    rx_idle_pct = 68;

    // Directed: extremes, duplicate insert, absent remove, reads in and out
    // of range, the unused opcode, and removes at the head, middle and tail.
    send_beat(OP_INSERT, 32'h8000_0000, IW'($urandom_range(15)));
    send_beat(OP_INSERT, 32'h7FFF_FFFF, IW'($urandom_range(15)));
    send_beat(OP_INSERT, 32'h7FFF_FFFF, IW'($urandom_range(15)));
    send_beat(OP_REMOVE, 32'h0000_3039, IW'($urandom_range(15)));
    send_beat(OP_READ,   $urandom, 4'd0);
    send_beat(OP_READ,   $urandom, 4'd1);
    send_beat(OP_READ,   $urandom, 4'd2);
    send_beat(OP_READ,   $urandom, 4'd15);
    send_beat(OP_UNUSED, $urandom, IW'($urandom_range(15)));
    send_beat(OP_REMOVE, 32'h8000_0000, IW'($urandom_range(15)));
    // Fill the set: one member left, fifteen distinct values bring it to DEPTH.
    for (int k = 0; k < DEPTH - 1; k++)
      send_beat(OP_INSERT, k * 32'h1111_1111, IW'($urandom_range(15)));
    // Full set: a new value is refused, a present one reports no change.
    send_beat(OP_INSERT, 32'hFFFF_FFFF, IW'($urandom_range(15)));
    send_beat(OP_INSERT, 32'h7FFF_FFFF, IW'($urandom_range(15)));
    send_beat(OP_READ,   $urandom, 4'd15);
    send_beat(OP_REMOVE, 32'h7777_7777, IW'($urandom_range(15)));
    send_beat(OP_REMOVE, 32'hEEEE_EEEE, IW'($urandom_range(15)));
    pause_until_drained();

    // Random: sender light and receiver heavy, then swapped, then no idling
    // with one long receiver hold-off to back the block up.
    run_random_phase(9, 68, 1'b0);
    run_random_phase(68, 9, 1'b0);
    run_random_phase(0, 0, 1'b1);

    // Let any stray late result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
